FILE: sv/etcache_pkg.sv
package etcache_pkg;

  // default table geometry
  localparam int LOW_ENTRIES_DEF     = 1024;
  localparam int HIGH_ENTRIES_DEF    = 4096;
  localparam int HIGH_EPOCH_BITS_DEF = 17;

  // field widths and stream word widths
  localparam int MODE_W   = 2;
  localparam int DESC_W   = 32;
  localparam int CLASS_W  = 3;
  localparam int EPOCH_W  = 32;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  // class codes
  localparam logic [CLASS_W-1:0] CLASS_NONE     = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_STREAM   = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_DATAGRAM = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_MAX      = 3'd4;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_STORE  = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_BUMP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EVAL
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic sweep;   // clear one table row
    logic accept;  // capture word and read tables
    logic eval;    // compare, write back, load result
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;  // last row of the clearing pass
    logic out_busy;    // result register held and not taken this cycle
  } dp_status_t;

endpackage

FILE: sv/etcache_ctrl.sv
module etcache_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  etcache_pkg::dp_status_t status,
  output etcache_pkg::ctrl_cmd_t  cmd
);

  etcache_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etcache_pkg::ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      etcache_pkg::ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_next = etcache_pkg::ST_IDLE;
        end
      end
      etcache_pkg::ST_IDLE: begin
        s_tready = !status.out_busy;
        if (s_tvalid && !status.out_busy) begin
          cmd.accept = 1'b1;
          state_next = etcache_pkg::ST_EVAL;
        end
      end
      etcache_pkg::ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = etcache_pkg::ST_IDLE;
      end
      default: begin
        state_next = etcache_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/etcache_dp.sv
module etcache_dp #(
  parameter int LOW_ENTRIES     = etcache_pkg::LOW_ENTRIES_DEF,
  parameter int HIGH_ENTRIES    = etcache_pkg::HIGH_ENTRIES_DEF,
  parameter int HIGH_EPOCH_BITS = etcache_pkg::HIGH_EPOCH_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  etcache_pkg::ctrl_cmd_t                cmd,
  output etcache_pkg::dp_status_t               status,
  input  logic [etcache_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [etcache_pkg::OUT_DATA_W-1:0]    m_tdata
);

  localparam int CW      = etcache_pkg::CLASS_W;
  localparam int EW      = etcache_pkg::EPOCH_W;
  localparam int LIDX_W  = $clog2(LOW_ENTRIES);
  localparam int HIDX_W  = $clog2(HIGH_ENTRIES);
  localparam int TAG_W   = etcache_pkg::DESC_W - 1 - HIDX_W;
  localparam int LO_W    = EW + CW;
  localparam int HI_W    = TAG_W + HIGH_EPOCH_BITS + CW;
  localparam int SWEEP_LEN = (LOW_ENTRIES > HIGH_ENTRIES) ? LOW_ENTRIES : HIGH_ENTRIES;
  localparam int SW_W    = $clog2(SWEEP_LEN);

  // captured item
  etcache_pkg::mode_t            mode_r;
  logic [etcache_pkg::DESC_W-1:0] desc_r;
  logic [CW-1:0]                 cin_r;
  logic [CW-1:0]                 cin_raw;

  logic [EW-1:0]   epoch;
  logic [SW_W-1:0] sweep_cnt;

  // tables and registered read data
  logic [LO_W-1:0] lo_mem [LOW_ENTRIES];
  logic [HI_W-1:0] hi_mem [HIGH_ENTRIES];
  logic [LO_W-1:0] lo_rdata;
  logic [HI_W-1:0] hi_rdata;

  logic              lo_we, hi_we;
  logic [LIDX_W-1:0] lo_waddr;
  logic [HIDX_W-1:0] hi_waddr;
  logic [LO_W-1:0]   lo_wdata;
  logic [HI_W-1:0]   hi_wdata;

  // evaluation signals
  logic                       neg, is_low, is_lookup;
  logic [EW-1:0]              lo_ep;
  logic [CW-1:0]              lo_cls;
  logic [TAG_W-1:0]           hi_tag;
  logic [HIGH_EPOCH_BITS-1:0] hi_ep;
  logic [CW-1:0]              hi_cls;
  logic [TAG_W-1:0]           tag;
  logic [HIGH_EPOCH_BITS-1:0] cur_hep;
  logic                       lo_hit, hi_cur, hi_match, hit;
  logic                       ev_lo_we, ev_hi_we;
  logic [CW-1:0]              ev_lo_cls, ev_hi_cls;
  logic [CW-1:0]              res_cls;

  // result register
  logic [CW-1:0] out_cls;
  logic          out_hit;

  assign cin_raw = s_tdata[etcache_pkg::MODE_W + etcache_pkg::DESC_W +: CW];

  // capture accepted word, class codes above the top one count as unknown
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= etcache_pkg::mode_t'(s_tdata[etcache_pkg::MODE_W-1:0]);
      desc_r <= s_tdata[etcache_pkg::MODE_W +: etcache_pkg::DESC_W];
      cin_r  <= (cin_raw > etcache_pkg::CLASS_MAX) ? etcache_pkg::CLASS_NONE : cin_raw;
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= sweep_cnt + 1'b1;
    end
  end

  assign status.sweep_last = (sweep_cnt == SW_W'(SWEEP_LEN - 1));
  assign status.out_busy   = m_tvalid && !m_tready;

  // decode of the captured item against the read entries
  assign neg       = desc_r[etcache_pkg::DESC_W-1];
  assign is_low    = (desc_r < 32'(LOW_ENTRIES));
  assign is_lookup = (mode_r == etcache_pkg::MODE_LOOKUP);

  assign lo_ep  = lo_rdata[LO_W-1 -: EW];
  assign lo_cls = lo_rdata[CW-1:0];
  assign hi_tag = hi_rdata[HI_W-1 -: TAG_W];
  assign hi_ep  = hi_rdata[CW +: HIGH_EPOCH_BITS];
  assign hi_cls = hi_rdata[CW-1:0];

  assign tag     = desc_r[etcache_pkg::DESC_W-2:HIDX_W];
  assign cur_hep = epoch[HIGH_EPOCH_BITS-1:0];

  assign lo_hit   = (lo_ep == epoch) && (lo_cls != etcache_pkg::CLASS_NONE);
  assign hi_cur   = (hi_ep == cur_hep);
  assign hi_match = hi_cur && (hi_tag == tag);

  // per-mode write-back decision
  always_comb begin
    ev_lo_we  = 1'b0;
    ev_hi_we  = 1'b0;
    ev_lo_cls = cin_r;
    ev_hi_cls = cin_r;
    hit       = 1'b0;
    res_cls   = etcache_pkg::CLASS_NONE;
    if (!neg && (mode_r != etcache_pkg::MODE_BUMP)) begin
      if (is_low) begin
        unique case (mode_r)
          etcache_pkg::MODE_LOOKUP: begin
            if (lo_hit) begin
              hit     = 1'b1;
              res_cls = lo_cls;
            end else begin
              ev_lo_we = (cin_r != etcache_pkg::CLASS_NONE);
              res_cls  = cin_r;
            end
          end
          etcache_pkg::MODE_STORE: begin
            ev_lo_we = (cin_r != etcache_pkg::CLASS_NONE);
          end
          default: begin
            ev_lo_we  = 1'b1;
            ev_lo_cls = etcache_pkg::CLASS_NONE;
          end
        endcase
      end else begin
        unique case (mode_r)
          etcache_pkg::MODE_LOOKUP: begin
            if (hi_match && (hi_cls != etcache_pkg::CLASS_NONE)) begin
              hit     = 1'b1;
              res_cls = hi_cls;
            end else begin
              ev_hi_we = (cin_r != etcache_pkg::CLASS_NONE);
              res_cls  = cin_r;
            end
          end
          etcache_pkg::MODE_STORE: begin
            ev_hi_we = (cin_r != etcache_pkg::CLASS_NONE);
          end
          default: begin
            // a current entry of another tag survives a clear
            ev_hi_we  = !hi_cur || hi_match;
            ev_hi_cls = etcache_pkg::CLASS_NONE;
          end
        endcase
      end
    end
  end

  // write port select: clearing pass or write-back
  always_comb begin
    lo_we    = 1'b0;
    hi_we    = 1'b0;
    lo_waddr = desc_r[LIDX_W-1:0];
    hi_waddr = desc_r[HIDX_W-1:0];
    lo_wdata = {epoch, ev_lo_cls};
    hi_wdata = {tag, cur_hep, ev_hi_cls};
    if (cmd.sweep) begin
      lo_we    = (32'(sweep_cnt) < 32'(LOW_ENTRIES));
      hi_we    = (32'(sweep_cnt) < 32'(HIGH_ENTRIES));
      lo_waddr = sweep_cnt[LIDX_W-1:0];
      hi_waddr = sweep_cnt[HIDX_W-1:0];
      lo_wdata = '0;
      hi_wdata = '0;
    end else if (cmd.eval) begin
      lo_we = ev_lo_we;
      hi_we = ev_hi_we;
    end
  end

  // low table
  always_ff @(posedge clk) begin
    if (lo_we) begin
      lo_mem[lo_waddr] <= lo_wdata;
    end
    if (cmd.accept) begin
      lo_rdata <= lo_mem[s_tdata[etcache_pkg::MODE_W +: LIDX_W]];
    end
  end

  // high table
  always_ff @(posedge clk) begin
    if (hi_we) begin
      hi_mem[hi_waddr] <= hi_wdata;
    end
    if (cmd.accept) begin
      hi_rdata <= hi_mem[s_tdata[etcache_pkg::MODE_W +: HIDX_W]];
    end
  end

  // epoch counter
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch <= '0;
    end else if (cmd.eval && (mode_r == etcache_pkg::MODE_BUMP)) begin
      epoch <= epoch + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.eval) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      out_cls <= is_lookup ? res_cls : etcache_pkg::CLASS_NONE;
      out_hit <= hit;
    end
  end

  assign m_tdata = {2'b00,
                    (out_cls == etcache_pkg::CLASS_DATAGRAM),
                    (out_cls == etcache_pkg::CLASS_STREAM),
                    out_hit,
                    out_cls};

endmodule

FILE: sv/epoch_tagged_type_cache_top.sv
// channel   dir  handshake            payload
// s_        in   s_tvalid / s_tready  s_tdata: mode, descriptor, class_in
// m_        out  m_tvalid / m_tready  m_tdata: class_out, was_hit, is_stream, is_datagram
//
// each word passes through an accept step that reads both tables and then an
// evaluate step that compares, writes back and loads the result register; no
// new word is taken before that, as each synchronous table is read-modify-written
// after reset a clearing pass over max(LOW_ENTRIES, HIGH_ENTRIES) rows
// (4096 at the defaults) zeroes the tables; no word is accepted meanwhile
// a held result blocks only the next accept, never the one being evaluated
module epoch_tagged_type_cache_top #(
  parameter int LOW_ENTRIES     = etcache_pkg::LOW_ENTRIES_DEF,
  parameter int HIGH_ENTRIES    = etcache_pkg::HIGH_ENTRIES_DEF,
  parameter int HIGH_EPOCH_BITS = etcache_pkg::HIGH_EPOCH_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [1:0] mode, [33:2] descriptor, [36:34] class_in, [39:37] zero
  input  logic [etcache_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [2:0] class_out, [3] was_hit, [4] is_stream, [5] is_datagram, [7:6] zero
  output logic [etcache_pkg::OUT_DATA_W-1:0] m_tdata
);

  etcache_pkg::ctrl_cmd_t  cmd;
  etcache_pkg::dp_status_t status;

  etcache_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  etcache_dp #(
    .LOW_ENTRIES     (LOW_ENTRIES),
    .HIGH_ENTRIES    (HIGH_ENTRIES),
    .HIGH_EPOCH_BITS (HIGH_EPOCH_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // no word taken while a result is held back
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !(m_tvalid && !m_tready))
    else $error("word accepted while result register blocked");

  // every accepted word shows a result, loaded in its evaluate step
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> ##2 m_tvalid)
    else $error("result missing after accepted word");

  // a hit always carries a known class
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3]) |-> (m_tdata[2:0] != etcache_pkg::CLASS_NONE))
    else $error("hit reported with unknown class");

endmodule
